@@ rtl/core/fenwick_prefix_sum_table_unit_assert.svh @@
// Assertion macros for the prefix sum table controller.
`ifndef FENWICK_PREFIX_SUM_TABLE_UNIT_ASSERT_SVH
`define FENWICK_PREFIX_SUM_TABLE_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define FPST_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fpst: same-cycle check failed");

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define FPST_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fpst: next-cycle check failed");

`else

`define FPST_ASSERT_IMPLY(label, ante, cons)
`define FPST_ASSERT_NEXT(label, ante, cons)

`endif

`endif

@@ rtl/core/fpst_pkg.sv @@
// Types, constants and command structures for the prefix sum table.
package fpst_pkg;

    // Tree geometry.
    localparam int MAX_ENTRIES = 1024;
    localparam int ADDR_W      = $clog2(MAX_ENTRIES);
    // Node walk index: one-based, and may step up to twice the table size.
    localparam int WALK_W      = ADDR_W + 2;

    // Field widths.
    localparam int DATA_W = 64;
    localparam int IDX_W  = 10;
    localparam int SIZE_W = 11;
    localparam int CMP_W  = (ADDR_W + 1 > SIZE_W) ? ADDR_W + 1 : SIZE_W;

    localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(1024);

    // Operation codes.
    localparam logic [1:0] MODE_ADD    = 2'd0;
    localparam logic [1:0] MODE_PREFIX = 2'd1;
    localparam logic [1:0] MODE_RANGE  = 2'd2;
    localparam logic [1:0] MODE_NONE   = 2'd3;

    typedef struct packed {
        logic [1:0]               mode;
        logic [IDX_W-1:0]         index;
        logic [IDX_W-1:0]         left_index;
        logic signed [DATA_W-1:0] delta;
    } in_item_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] total;
        logic                     out_of_range;
    } out_item_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clear_wr;     // write zero at the clearing counter
        logic load_item;    // capture the accepted request
        logic add_rd;       // read the node under the walk index
        logic add_wr;       // write node plus delta, step the walk upward
        logic q_rd;         // read the node for a query, step the walk downward
        logic load_left;    // start the subtracting pass at the left end
        logic result_load;  // move the result into the output register
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clear_last;   // clearing counter at the last entry
        logic in_oor;       // presented request has an index out of range
        logic walk_zero;    // downward walk has finished
        logic walk_above;   // upward walk has left the tree
        logic pend;         // a query read is still in flight
        logic out_busy;     // output register full and stalled
    } dp_status_t;

endpackage

@@ rtl/core/fpst_datapath.sv @@
// Datapath of the prefix sum table: node memory, walk index, accumulator and output register.
module fpst_datapath (
    input  logic               clk,
    input  logic               rst_n,
    input  fpst_pkg::in_item_t item,
    input  logic               size_we,
    input  logic [fpst_pkg::SIZE_W-1:0] size_wdata,
    input  fpst_pkg::dp_cmd_t  cmd,
    output fpst_pkg::dp_status_t status,
    output logic               result_valid,
    input  logic               result_stall,
    output fpst_pkg::out_item_t result
);
    import fpst_pkg::*;

    logic [DATA_W-1:0] mem [MAX_ENTRIES];

    logic [SIZE_W-1:0] size_reg;
    logic [ADDR_W-1:0] clr_cnt_reg, clr_cnt_next;
    logic [WALK_W-1:0] walk_reg, walk_next;
    logic [DATA_W-1:0] acc_reg, acc_next;
    logic              sub_reg, sub_next;
    logic              pend_reg;
    logic              oor_reg;
    logic [DATA_W-1:0] delta_reg;
    logic [IDX_W-1:0]  left_reg;
    logic [DATA_W-1:0] rdata_reg;
    logic              res_valid_reg, res_valid_next;
    out_item_t         res_reg;

    logic [CMP_W-1:0]  eff_size;
    logic [CMP_W-1:0]  idx_ext;
    logic [CMP_W-1:0]  left_ext;
    logic              in_oor;
    logic [WALK_W-1:0] low_bit;
    logic [WALK_W-1:0] walk_m1;
    logic [ADDR_W-1:0] node_addr;
    logic [DATA_W-1:0] node_sum;

    // Effective size is the register capped at the table size.
    always_comb
    begin
        if (CMP_W'(size_reg) > CMP_W'(MAX_ENTRIES))
        begin
            eff_size = CMP_W'(MAX_ENTRIES);
        end
        else
        begin
            eff_size = CMP_W'(size_reg);
        end
    end

    assign idx_ext  = CMP_W'(item.index);
    assign left_ext = CMP_W'(item.left_index);

    // Range check of the request at the input.
    always_comb
    begin
        unique case (item.mode)
            MODE_ADD, MODE_PREFIX: in_oor = (idx_ext >= eff_size);
            MODE_RANGE:            in_oor = (idx_ext >= eff_size) ||
                                            (left_ext >= eff_size);
            default:               in_oor = 1'b0;
        endcase
    end

    assign status.in_oor = in_oor;

    // Lowest set bit of the walk index, and the node address it selects.
    assign low_bit   = walk_reg & (~walk_reg + WALK_W'(1));
    assign walk_m1   = walk_reg - WALK_W'(1);
    assign node_addr = walk_m1[ADDR_W-1:0];
    assign node_sum  = rdata_reg + delta_reg;

    assign status.clear_last = (clr_cnt_reg == ADDR_W'(MAX_ENTRIES - 1));
    assign status.walk_zero  = (walk_reg == '0);
    assign status.walk_above = (walk_reg > WALK_W'(MAX_ENTRIES));
    assign status.pend       = pend_reg;
    assign status.out_busy   = res_valid_reg && result_stall;

    // Next values of the walk and accumulation registers.
    always_comb
    begin
        clr_cnt_next = clr_cnt_reg;
        walk_next    = walk_reg;
        acc_next     = acc_reg;
        sub_next     = sub_reg;
        if (cmd.clear_wr)
        begin
            clr_cnt_next = clr_cnt_reg + ADDR_W'(1);
        end
        priority if (cmd.load_item)
        begin
            walk_next = WALK_W'(item.index) + WALK_W'(1);
        end
        else if (cmd.load_left)
        begin
            walk_next = WALK_W'(left_reg);
        end
        else if (cmd.add_wr)
        begin
            walk_next = walk_reg + low_bit;
        end
        else if (cmd.q_rd)
        begin
            walk_next = walk_reg - low_bit;
        end
        else
        begin
            walk_next = walk_reg;
        end
        if (cmd.load_item)
        begin
            acc_next = '0;
            sub_next = 1'b0;
        end
        else
        begin
            if (pend_reg)
            begin
                acc_next = sub_reg ? acc_reg - rdata_reg : acc_reg + rdata_reg;
            end
            if (cmd.load_left)
            begin
                sub_next = 1'b1;
            end
        end
    end

    // Output register: loaded on command, emptied when taken.
    always_comb
    begin
        if (cmd.result_load)
        begin
            res_valid_next = 1'b1;
        end
        else
        begin
            res_valid_next = res_valid_reg && result_stall;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg      <= SIZE_RESET;
            clr_cnt_reg   <= '0;
            walk_reg      <= '0;
            sub_reg       <= 1'b0;
            pend_reg      <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (size_we)
            begin
                size_reg <= size_wdata;
            end
            clr_cnt_reg   <= clr_cnt_next;
            walk_reg      <= walk_next;
            sub_reg       <= sub_next;
            pend_reg      <= cmd.q_rd;
            res_valid_reg <= res_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        if (cmd.load_item)
        begin
            oor_reg   <= in_oor;
            delta_reg <= item.delta;
            left_reg  <= item.left_index;
        end
        if (cmd.result_load)
        begin
            res_reg.total        <= oor_reg ? '0 : acc_reg;
            res_reg.out_of_range <= oor_reg;
        end
    end

    // Node memory write port: clearing pass or add write-back.
    always_ff @(posedge clk)
    begin
        if (cmd.clear_wr)
        begin
            mem[clr_cnt_reg] <= '0;
        end
        else if (cmd.add_wr)
        begin
            mem[node_addr] <= node_sum;
        end
    end

    // Node memory read port with registered data, used by add and query walks.
    always_ff @(posedge clk)
    begin
        if (cmd.add_rd || cmd.q_rd)
        begin
            rdata_reg <= mem[node_addr];
        end
    end

    assign result_valid = res_valid_reg;
    assign result       = res_reg;

endmodule

@@ rtl/core/fpst_controller.sv @@
// Controller of the prefix sum table: sequences clearing, add walks and query walks.
`include "fenwick_prefix_sum_table_unit_assert.svh"

module fpst_controller (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    input  logic [1:0]           item_mode,
    output logic                 item_stall,
    input  fpst_pkg::dp_status_t status,
    output fpst_pkg::dp_cmd_t    cmd
);
    import fpst_pkg::*;

    localparam logic [2:0] S_CLEAR  = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_ADD_RD = 3'd2;
    localparam logic [2:0] S_ADD_WR = 3'd3;
    localparam logic [2:0] S_WALK   = 3'd4;
    localparam logic [2:0] S_RESULT = 3'd5;

    logic [2:0] state_reg, state_next;
    logic       range_reg, range_next;
    logic       accept;

    assign item_stall = (state_reg != S_IDLE);
    assign accept     = item_valid && (state_reg == S_IDLE);

    // Next state and commands.
    always_comb
    begin
        state_next = state_reg;
        range_next = range_reg;
        cmd        = '0;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clear_wr = 1'b1;
                if (status.clear_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd.load_item = 1'b1;
                    range_next    = (item_mode == MODE_RANGE);
                    priority if (item_mode == MODE_NONE)
                    begin
                        state_next = S_IDLE;
                    end
                    else if (status.in_oor)
                    begin
                        state_next = S_RESULT;
                    end
                    else if (item_mode == MODE_ADD)
                    begin
                        state_next = S_ADD_RD;
                    end
                    else
                    begin
                        state_next = S_WALK;
                    end
                end
            end
            S_ADD_RD:
            begin
                if (status.walk_above)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd.add_rd = 1'b1;
                    state_next = S_ADD_WR;
                end
            end
            S_ADD_WR:
            begin
                cmd.add_wr = 1'b1;
                state_next = S_ADD_RD;
            end
            S_WALK:
            begin
                // One node read a cycle until the index reaches zero, then drain.
                if (!status.walk_zero)
                begin
                    cmd.q_rd = 1'b1;
                end
                else if (!status.pend)
                begin
                    if (range_reg)
                    begin
                        cmd.load_left = 1'b1;
                        range_next    = 1'b0;
                    end
                    else
                    begin
                        state_next = S_RESULT;
                    end
                end
            end
            S_RESULT:
            begin
                if (!status.out_busy)
                begin
                    cmd.result_load = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            range_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            range_reg <= range_next;
        end
    end

    // Every node read of an add is followed by its write-back.
    `FPST_ASSERT_NEXT(a_add_write_follows_read, cmd.add_rd, cmd.add_wr)
    // A result is only loaded when the output register has room.
    `FPST_ASSERT_IMPLY(a_result_has_room, cmd.result_load, !status.out_busy)
    // No request is taken during the clearing pass.
    `FPST_ASSERT_IMPLY(a_no_request_while_clearing, state_reg == S_CLEAR, item_stall)
    // The clearing pass owns the memory port alone.
    `FPST_ASSERT_IMPLY(a_clear_exclusive, cmd.clear_wr,
        !cmd.add_wr && !cmd.add_rd && !cmd.q_rd)

endmodule

@@ rtl/core/fenwick_prefix_sum_table_unit.sv @@
// Top level of the prefix sum table: controller and datapath.
//
// Usage: a request (item_valid, item) carries a point add, a prefix query or a
// range query; it is taken at a clock edge with item_valid high and item_stall low.
// Queries, and any request with an index at or beyond the size in use, give one
// result on (result_valid, result), taken when result_stall is low. An add
// in range and an unused mode give no result. size_we writes size_wdata into the
// size register; writes leave the tree untouched.
// An add walks up at most 11 nodes, each with one memory read and one write-back,
// and ends when the walk is seen to leave the tree. A query reads one node a cycle
// (at most 10 a pass) and drains the last read; a range query then makes a second,
// subtracting pass from its left end, and the result is loaded last.
// Requests are handled one at a time: the next one is taken once the previous add
// or query has finished, even while the result still sits in the output register.
// After reset a clearing pass writes zero to all 1024 nodes, one a cycle, and
// item_stall stays high throughout the pass. When the receiver stalls, the result
// holds and a further query waits before loading its own result.
module fenwick_prefix_sum_table_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          item_valid,
    output logic                          item_stall,
    input  fpst_pkg::in_item_t            item,
    output logic                          result_valid,
    input  logic                          result_stall,
    output fpst_pkg::out_item_t           result,
    input  logic                          size_we,
    input  logic [fpst_pkg::SIZE_W-1:0]   size_wdata
);
    import fpst_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    // Sequencer.
    fpst_controller u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_mode  (item.mode),
        .item_stall (item_stall),
        .status     (status),
        .cmd        (cmd)
    );

    // Memory, walk and output datapath.
    fpst_datapath u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .size_we      (size_we),
        .size_wdata   (size_wdata),
        .cmd          (cmd),
        .status       (status),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

@@ verif/testbench.sv @@
// Self-checking testbench for the prefix sum table: point adds, prefix and range queries.
module testbench;

    import fpst_pkg::*;

    localparam int CLK_HALF   = 4;
    localparam int SETTLE     = 40;      // longer than the slowest add or query
    localparam int CYCLE_CAP  = 300000;
    localparam int PHASE_REQS = 45;

    // Tracks the true counter values and the queries still owed a result.
    class prefix_sum_checker;
        logic signed [DATA_W-1:0] position_sum [MAX_ENTRIES];
        int                       size_setting;
        out_item_t                owed_results [$];
        int                       errors;

        function new();
            foreach (position_sum[i])
                position_sum[i] = '0;
            size_setting = int'(SIZE_RESET);
            errors       = 0;
        endfunction

        // Sum of positions 0 to last inclusive; wraps modulo 2^64.
        function logic signed [DATA_W-1:0] sum_through(int last);
            logic signed [DATA_W-1:0] acc;
            acc = '0;
            for (int i = 0; i <= last; i++)
                acc += position_sum[i];
            return acc;
        endfunction

        // Applies an accepted request and queues the result it should give.
        function void note_request(in_item_t req);
            out_item_t res;
            int        span;
            int        right_end;
            int        left_end;
            span      = (size_setting > MAX_ENTRIES) ? MAX_ENTRIES : size_setting;
            right_end = int'(req.index);
            left_end  = int'(req.left_index);
            res.total        = '0;
            res.out_of_range = 1'b1;
            case (req.mode)
                MODE_ADD:
                begin
                    if (right_end < span)
                        position_sum[right_end] += req.delta;
                    else
                        owed_results = {owed_results, res};
                end
                MODE_PREFIX:
                begin
                    if (right_end < span)
                    begin
                        res.total        = sum_through(right_end);
                        res.out_of_range = 1'b0;
                    end
                    owed_results = {owed_results, res};
                end
                MODE_RANGE:
                begin
                    if (right_end < span && left_end < span)
                    begin
                        // A left end above the right end gives a negated sum.
                        res.total = sum_through(right_end)
                                  - ((left_end == 0) ? '0 : sum_through(left_end - 1));
                        res.out_of_range = 1'b0;
                    end
                    owed_results = {owed_results, res};
                end
                default:
                begin
                end
            endcase
        endfunction

        task report_mismatch(string what);
            $display("mismatch at %0t: %s", $realtime, what);
            errors++;
        endtask

        // Compares a delivered result with the oldest one owed.
        task check_result(out_item_t got);
            out_item_t want;
            if (owed_results.size() == 0)
            begin
                report_mismatch($sformatf("result total %0d with no request waiting", got.total));
            end
            else
            begin
                want = owed_results.pop_front();
                if (got.total !== want.total)
                    report_mismatch($sformatf("total %0d, expected %0d",
                                              got.total, want.total));
                if (got.out_of_range !== want.out_of_range)
                    report_mismatch($sformatf("out_of_range %0b, expected %0b",
                                              got.out_of_range, want.out_of_range));
            end
        endtask

        function int pending();
            return owed_results.size();
        endfunction
    endclass

    logic                clk = 1'b0;
    logic                rst_n;
    logic                item_valid;
    logic                item_stall;
    in_item_t            item;
    logic                result_valid;
    logic                result_stall = 1'b0;
    out_item_t           result;
    logic                size_we;
    logic [SIZE_W-1:0]   size_wdata;

    prefix_sum_checker   sums;
    int                  sender_idle_pct;
    int                  receiver_stall_pct;
    int                  cycle_count = 0;
    int                  phase_sizes [8];

    fenwick_prefix_sum_table_unit DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .size_we      (size_we),
        .size_wdata   (size_wdata)
    );

    always #CLK_HALF clk = ~clk;

    // Cycle count with a hard limit on the run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_CAP)
        begin
            $display("testbench NOT OK");
            $finish;
        end
    end

    // Random back-pressure on the result side.
    always @(posedge clk)
    begin
        result_stall <= ($urandom_range(99) < receiver_stall_pct);
    end

    // Every accepted result is checked against the oldest one owed.
    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
            sums.check_result(result);
    end

    function automatic in_item_t make_request(logic [1:0] mode, int idx, int left,
                                              logic signed [DATA_W-1:0] delta);
        in_item_t req;
        req.mode       = mode;
        req.index      = IDX_W'(idx);
        req.left_index = IDX_W'(left);
        req.delta      = delta;
        return req;
    endfunction

    // Mostly positions inside the covered span, some anywhere.
    function automatic int pick_position(int span);
        if (span > 0 && $urandom_range(99) < 85)
            return $urandom_range(span - 1);
        return $urandom_range(1023);
    endfunction

    function automatic logic signed [DATA_W-1:0] pick_delta();
        case ($urandom_range(9))
            0: return 64'sh7FFF_FFFF_FFFF_FFFF;
            1: return 64'sh8000_0000_0000_0000;
            2: return -64'sd1;
            3, 4, 5: return DATA_W'($signed($urandom_range(2000)) - 1000);
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic in_item_t random_request(int span);
        logic [1:0] mode;
        int         pick;
        pick = $urandom_range(99);
        if (pick < 40)
            mode = MODE_ADD;
        else if (pick < 65)
            mode = MODE_PREFIX;
        else if (pick < 95)
            mode = MODE_RANGE;
        else
            mode = MODE_NONE;
        return make_request(mode, pick_position(span), pick_position(span), pick_delta());
    endfunction

    // Presents one request, with an optional idle gap first, and waits for it to be taken.
    task automatic send_request(in_item_t req);
        int gap;
        gap = 0;
        while ($urandom_range(99) < sender_idle_pct)
            gap++;
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item       <= req;
        item_valid <= 1'b1;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        sums.note_request(req);
    endtask

    // Drops valid and waits until every owed result is in and the block has settled.
    task automatic drain();
        item_valid <= 1'b0;
        while (sums.pending() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_size(int value);
        size_we    <= 1'b1;
        size_wdata <= SIZE_W'(value);
        @(posedge clk);
        sums.size_setting = value;
        size_we <= 1'b0;
    endtask

    initial
    begin
        int span;
        int sent;
        in_item_t req;

        sums = new();
        rst_n              <= 1'b0;
        item_valid         <= 1'b0;
        item               <= '0;
        size_we            <= 1'b0;
        size_wdata         <= '0;
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Directed requests over the full span: extremes, wrap-around and reversed ranges.
        send_request(make_request(MODE_PREFIX, 0, 0, '0));
        send_request(make_request(MODE_ADD, 0, 1023, 64'sh7FFF_FFFF_FFFF_FFFF));
        send_request(make_request(MODE_ADD, 1023, 0, 64'sh8000_0000_0000_0000));
        send_request(make_request(MODE_ADD, 511, 0, -64'sd1));
        send_request(make_request(MODE_ADD, 512, 1023, 64'sd1));
        send_request(make_request(MODE_ADD, 0, 0, 64'sd5));
        send_request(make_request(MODE_PREFIX, 1023, 1023, -64'sd1));
        send_request(make_request(MODE_PREFIX, 0, 0, '0));
        send_request(make_request(MODE_RANGE, 1023, 0, '0));
        send_request(make_request(MODE_RANGE, 0, 0, '0));
        send_request(make_request(MODE_RANGE, 100, 600, '0));
        send_request(make_request(MODE_RANGE, 1023, 1023, '0));
        send_request(make_request(MODE_NONE, 1023, 1023, -64'sd1));
        send_request(make_request(MODE_PREFIX, 600, 0, '0));
        drain();

        // Smallest covered span: only position 0 is valid.
        write_size(1);
        send_request(make_request(MODE_ADD, 0, 0, 64'sd7));
        send_request(make_request(MODE_ADD, 1, 0, 64'sd9));
        send_request(make_request(MODE_PREFIX, 1, 0, '0));
        send_request(make_request(MODE_RANGE, 0, 5, '0));
        send_request(make_request(MODE_RANGE, 5, 0, '0));
        send_request(make_request(MODE_PREFIX, 0, 0, '0));
        drain();

        // An empty span rejects everything; an oversized one is capped at the table size.
        write_size(0);
        send_request(make_request(MODE_PREFIX, 0, 0, '0));
        send_request(make_request(MODE_ADD, 0, 0, 64'sd3));
        drain();
        write_size(2047);
        send_request(make_request(MODE_PREFIX, 1023, 0, '0));
        drain();

        // Random phases, each with its own span and idling pattern.
        phase_sizes    = '{1024, 1, 2047, 16, 1024, 1000, 2, 1024};
        phase_sizes[5] = $urandom_range(1023, 2);
        for (int phase = 0; phase < 8; phase++)
        begin
            write_size(phase_sizes[phase]);
            case (phase % 4)
                0:
                begin
                    sender_idle_pct    = 0;
                    receiver_stall_pct = 0;
                end
                1:
                begin
                    sender_idle_pct    = 70;
                    receiver_stall_pct = 0;
                end
                2:
                begin
                    sender_idle_pct    = 0;
                    receiver_stall_pct = 70;
                end
                default:
                begin
                    sender_idle_pct    = 33;
                    receiver_stall_pct = 33;
                end
            endcase
            span = (phase_sizes[phase] > MAX_ENTRIES) ? MAX_ENTRIES : phase_sizes[phase];
            sent = 0;
            while (sent < PHASE_REQS)
            begin
                req = random_request(span);
                send_request(req);
                if (req.mode != MODE_NONE)
                    sent++;
            end
            drain();
        end

        receiver_stall_pct = 0;
        if (sums.pending() != 0)
            sums.report_mismatch($sformatf("%0d results never arrived", sums.pending()));
        if (sums.errors == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+rtl/core
rtl/core/fpst_pkg.sv
rtl/core/fpst_datapath.sv
rtl/core/fpst_controller.sv
rtl/core/fenwick_prefix_sum_table_unit.sv
verif/testbench.sv
